>>> src/bmpw_pkg.sv
package bmpw_pkg;

  localparam int unsigned SideW    = 13;
  localparam int unsigned CountW   = 12;
  localparam int unsigned MaxSide  = 4096;
  localparam int unsigned HdrBytes = 54;
  localparam int unsigned CntW     = 6;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [31:0] InfoBytes  = 32'd40;
  localparam logic [31:0] Resolution = 32'd11811;
  localparam logic [7:0]  BitsPerPix = 8'd24;
  localparam logic [7:0]  MagicB     = 8'h42;
  localparam logic [7:0]  MagicM     = 8'h4D;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_item;
    logic       last_of_file;
  } res_t;

  // One classified pixel as handed from the front to the back.
  typedef struct packed {
    pix_t             pix;
    logic             hdr;
    logic             file_end;
    logic [1:0]       pad;
    logic [SideW-1:0] w;
    logic [SideW-1:0] h;
  } entry_t;

  function automatic logic [7:0] le_byte(logic [31:0] v, logic [5:0] off);
    logic [1:0] k;
    k = off[1:0];
    return v[8*k +: 8];
  endfunction

  // Header byte at position idx; ds is the pixel data size, fs the file size.
  function automatic logic [7:0] hdr_byte(logic [CntW-1:0] idx, logic [SideW-1:0] w,
                                          logic [SideW-1:0] h, logic [31:0] ds,
                                          logic [31:0] fs);
    logic [7:0] b;
    b = 8'd0;
    unique case (idx) inside
      6'd0:          b = MagicB;
      6'd1:          b = MagicM;
      [6'd2:6'd5]:   b = le_byte(fs, idx - 6'd2);
      6'd10:         b = 8'(HdrBytes);
      6'd14:         b = InfoBytes[7:0];
      [6'd18:6'd21]: b = le_byte({19'd0, w}, idx - 6'd18);
      [6'd22:6'd25]: b = le_byte({19'd0, h}, idx - 6'd22);
      6'd26:         b = 8'd1;
      6'd28:         b = BitsPerPix;
      [6'd34:6'd37]: b = le_byte(ds, idx - 6'd34);
      [6'd38:6'd41]: b = le_byte(Resolution, idx - 6'd38);
      [6'd42:6'd45]: b = le_byte(Resolution, idx - 6'd42);
      default:       b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

>>> src/bmpw_front.sv
module bmpw_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [bmpw_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bmpw_pkg::SideW-1:0]      cfg_data_i,
  input  logic                            accept_i,
  input  bmpw_pkg::pix_t                  pix_i,
  output bmpw_pkg::entry_t                entry_o
);
  import bmpw_pkg::*;

  logic [SideW-1:0]  width_q, height_q;
  logic [CountW-1:0] col_q, col_d, row_q, row_d;
  logic [SideW-1:0]  w_cl, h_cl, col_inc, row_inc;
  logic              row_end, file_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SideW'(1);
      height_q <= SideW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_cl = width_q;
    if (width_q == '0) w_cl = SideW'(1);
    else if (width_q > SideW'(MaxSide)) w_cl = SideW'(MaxSide);
    h_cl = height_q;
    if (height_q == '0) h_cl = SideW'(1);
    else if (height_q > SideW'(MaxSide)) h_cl = SideW'(MaxSide);
  end

  assign col_inc  = {1'b0, col_q} + SideW'(1);
  assign row_inc  = {1'b0, row_q} + SideW'(1);
  assign row_end  = (col_inc >= w_cl);
  assign file_end = row_end && (row_inc >= h_cl);

  always_comb begin
    col_d = row_end ? '0 : col_inc[CountW-1:0];
    row_d = row_q;
    if (file_end) row_d = '0;
    else if (row_end) row_d = row_inc[CountW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // A row of w pixels holds 3w bytes, so the padding count is w mod 4.
  always_comb begin
    entry_o.pix      = pix_i;
    entry_o.hdr      = (col_q == '0) && (row_q == '0);
    entry_o.file_end = file_end;
    entry_o.pad      = row_end ? w_cl[1:0] : 2'd0;
    entry_o.w        = w_cl;
    entry_o.h        = h_cl;
  end

endmodule

>>> src/bmpw_queue.sv
module bmpw_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  bmpw_pkg::entry_t  wr_data_i,
  output logic              full_o,
  output logic              valid_o,
  output bmpw_pkg::entry_t  head_o,
  input  logic              rd_i
);
  import bmpw_pkg::*;

  entry_t             mem_q [QDepth];
  logic [QPtrW-1:0]   wp_q, rp_q;
  logic [QCntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= (wp_q == QPtrW'(QDepth - 1)) ? '0 : wp_q + QPtrW'(1);
      if (rd_i) rp_q <= (rp_q == QPtrW'(QDepth - 1)) ? '0 : rp_q + QPtrW'(1);
      if (wr_i && !rd_i) cnt_q <= cnt_q + QCntW'(1);
      else if (rd_i && !wr_i) cnt_q <= cnt_q - QCntW'(1);
    end
  end

endmodule

>>> src/bmpw_back.sv
module bmpw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  bmpw_pkg::entry_t  head_i,
  output logic              q_rd_o,
  output bmpw_pkg::res_t    result_o,
  output logic              empty,
  input  logic              pop
);
  import bmpw_pkg::*;

  typedef enum logic [1:0] {
    P_START,
    P_HDR,
    P_PIX,
    P_PAD
  } phase_e;

  phase_e          phase_q, phase_d, kind;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_v_q;
  res_t            out_q, res_d;
  logic            advance, last;
  logic [14:0]     row_sz;
  logic [31:0]     data_size_q, file_size_q;

  // The head entry stays put until its last byte, so these settle, first
  // data_size_q and then file_size_q, before header byte two needs them.
  assign row_sz = (15'(head_i.w) * 15'd3 + 15'd3) & ~15'd3;

  always_ff @(posedge clk_i) begin
    data_size_q <= 32'(28'(head_i.h) * 28'(row_sz));
    file_size_q <= data_size_q + 32'(HdrBytes);
  end

  assign advance = q_valid_i && (!out_v_q || pop);

  always_comb begin
    kind = phase_q;
    if (phase_q == P_START) kind = head_i.hdr ? P_HDR : P_PIX;
    phase_d = phase_q;
    cnt_d   = cnt_q + CntW'(1);
    last    = 1'b0;
    res_d.data_byte = 8'd0;
    unique case (kind)
      P_HDR: begin
        res_d.data_byte = hdr_byte(cnt_q, head_i.w, head_i.h, data_size_q, file_size_q);
        phase_d = P_HDR;
        if (cnt_q == CntW'(HdrBytes - 1)) begin
          phase_d = P_PIX;
          cnt_d   = '0;
        end
      end
      P_PIX: begin
        case (cnt_q[1:0])
          2'd0:    res_d.data_byte = head_i.pix.blue;
          2'd1:    res_d.data_byte = head_i.pix.green;
          default: res_d.data_byte = head_i.pix.red;
        endcase
        phase_d = P_PIX;
        if (cnt_q == CntW'(2)) begin
          cnt_d = '0;
          if (head_i.pad == 2'd0) begin
            last    = 1'b1;
            phase_d = P_START;
          end else begin
            phase_d = P_PAD;
          end
        end
      end
      P_PAD: begin
        if (cnt_q[1:0] == head_i.pad - 2'd1) begin
          last    = 1'b1;
          phase_d = P_START;
          cnt_d   = '0;
        end
      end
      default: ;
    endcase
    res_d.last_of_item = last;
    res_d.last_of_file = last && head_i.file_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_START;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
      out_q   <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      out_v_q <= 1'b1;
      out_q   <= res_d;
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  assign q_rd_o   = advance && last;
  assign result_o = out_q;
  assign empty    = !out_v_q;

  a_file_implies_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.last_of_file |-> out_q.last_of_item)
    else $error("last_of_file without last_of_item");

  a_hdr_only_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == P_HDR |-> q_valid_i && head_i.hdr)
    else $error("header phase on a pixel that does not open a frame");

  a_pad_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == P_PAD |-> q_valid_i && head_i.pad != 2'd0 && cnt_q[1:0] < head_i.pad)
    else $error("padding phase beyond the row padding");

  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd_o |=> out_v_q && out_q.last_of_item)
    else $error("queue entry retired without its last byte");

endmodule

>>> src/bmp_24bit_writer.sv
// Streams an image out as a 24-bit uncompressed BMP file, one byte per
// transaction. Pixels are pushed in file order (bottom row first, left to
// right); the first pixel of a frame brings out the 54-byte header, then each
// pixel gives blue, green, red, and the last pixel of a row adds zero padding
// up to a multiple of four bytes. The result register is one byte wide:
// a pixel gives 3 bytes, plus one per padding byte (0 to 3) when it
// ends a row, and 54 more when it opens a frame. A two-entry queue lets up to
// two pixels be pushed ahead of the byte stream. image_width and image_height
// are clamped to 1..4096 and should be written only while the block is idle.
module bmp_24bit_writer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bmpw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bmpw_pkg::SideW-1:0]    cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  bmpw_pkg::pix_t                pixel_i,
  output logic                          empty,
  input  logic                          pop,
  output bmpw_pkg::res_t                result_o
);
  import bmpw_pkg::*;

  entry_t entry, head;
  logic   accept, q_valid, q_rd;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  bmpw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .pix_i       (pixel_i),
    .entry_o     (entry)
  );

  bmpw_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept),
    .wr_data_i (entry),
    .full_o    (full),
    .valid_o   (q_valid),
    .head_o    (head),
    .rd_i      (q_rd)
  );

  bmpw_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .head_i    (head),
    .q_rd_o    (q_rd),
    .result_o  (result_o),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

>>> bench/bmp_24bit_writer_test.sv
`timescale 1ns / 100ps

module bmp_24bit_writer_test;
  import bmpw_pkg::*;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned HoldStretch = 120;

  // Tracks the image geometry and position, and holds the file bytes that
  // the block still owes for the pixels it has taken.
  class bmp_file_tracker;
    logic [SideW-1:0] width_reg;
    logic [SideW-1:0] height_reg;
    int unsigned      col_idx;
    int unsigned      row_idx;
    logic [7:0]       staged[$];
    res_t             bytes_due[$];
    int unsigned      failures;

    function new();
      width_reg  = 1;
      height_reg = 1;
      col_idx    = 0;
      row_idx    = 0;
      failures   = 0;
    endfunction

    function void note_register(logic [CfgIdxW-1:0] index, logic [SideW-1:0] value);
      if (index == REG_WIDTH) begin
        width_reg = value;
      end else if (index == REG_HEIGHT) begin
        height_reg = value;
      end
    endfunction

    function int unsigned clamp_side(logic [SideW-1:0] v);
      if (v == 0) return 1;
      if (v > MaxSide) return MaxSide;
      return int'(v);
    endfunction

    function void stage_byte(logic [7:0] b);
      staged = {staged, b};
    endfunction

    function void stage_le(logic [31:0] v, int unsigned nbytes);
      for (int unsigned k = 0; k < nbytes; k++) stage_byte(v[8*k +: 8]);
    endfunction

    function void add_pixel(pix_t p);
      int unsigned w;
      int unsigned h;
      int unsigned row_size;
      int unsigned data_size;
      bit          row_end;
      bit          file_end;
      res_t        r;
      w         = clamp_side(width_reg);
      h         = clamp_side(height_reg);
      row_size  = (3 * w + 3) & ~32'd3;
      data_size = h * row_size;
      row_end   = (col_idx + 1 >= w);
      file_end  = row_end && (row_idx + 1 >= h);
      staged.delete();
      if (col_idx == 0 && row_idx == 0) begin
        stage_byte(MagicB);
        stage_byte(MagicM);
        stage_le(data_size + HdrBytes, 4);
        stage_le(0, 4);
        stage_le(HdrBytes, 4);
        stage_le(InfoBytes, 4);
        stage_le(w, 4);
        stage_le(h, 4);
        stage_le(1, 2);
        stage_le(BitsPerPix, 2);
        stage_le(0, 4);
        stage_le(data_size, 4);
        stage_le(Resolution, 4);
        stage_le(Resolution, 4);
        stage_le(0, 4);
        stage_le(0, 4);
      end
      stage_byte(p.blue);
      stage_byte(p.green);
      stage_byte(p.red);
      if (row_end) begin
        for (int unsigned k = 0; k < row_size - 3 * w; k++) stage_byte(8'h00);
        col_idx = 0;
        row_idx = file_end ? 0 : ((row_idx + 1) & 32'hFFF);
      end else begin
        col_idx = (col_idx + 1) & 32'hFFF;
      end
      foreach (staged[i]) begin
        r.data_byte    = staged[i];
        r.last_of_item = (i == staged.size() - 1);
        r.last_of_file = r.last_of_item && file_end;
        bytes_due = {bytes_due, r};
      end
    endfunction

    function void check_byte(res_t got);
      res_t want;
      if (bytes_due.size() == 0) begin
        failures++;
        if (failures <= ReportLimit) begin
          $display("unexpected byte %02h (item end %0b, file end %0b) with nothing due",
                   got.data_byte, got.last_of_item, got.last_of_file);
        end
        return;
      end
      want = bytes_due.pop_front();
      if (got.data_byte !== want.data_byte || got.last_of_item !== want.last_of_item ||
          got.last_of_file !== want.last_of_file) begin
        failures++;
        if (failures <= ReportLimit) begin
          $display("byte mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                   want.data_byte, want.last_of_item, want.last_of_file,
                   got.data_byte, got.last_of_item, got.last_of_file);
        end
      end
    endfunction

    function void close_out();
      if (bytes_due.size() != 0) begin
        failures++;
        if (failures <= ReportLimit) begin
          $display("%0d bytes never came out", bytes_due.size());
        end
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [SideW-1:0]   cfg_data_i;
  logic               push;
  logic               full;
  pix_t               pixel_i;
  logic               empty;
  logic               pop;
  res_t               result_o;

  bmp_file_tracker board;
  pix_t            pixel_plan[$];
  bit              steady = 1'b0;
  int unsigned     hold_asks = 0;
  int unsigned     quiet_cycles = 0;

  bmp_24bit_writer DUT (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .push,
    .full,
    .pixel_i,
    .empty,
    .pop,
    .result_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic void plan_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] rd);
    pix_t p;
    p.blue  = b;
    p.green = g;
    p.red   = rd;
    pixel_plan = {pixel_plan, p};
  endfunction

  // Mostly small sides so that frames finish, now and then the extremes.
  function automatic logic [SideW-1:0] pick_side(int unsigned usual_max);
    logic [SideW-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      2:       v = SideW'(MaxSide);
      3:       v = SideW'($urandom_range(1, (1 << SideW) - 1));
      default: v = SideW'($urandom_range(1, usual_max));
    endcase
    return v;
  endfunction

  task automatic set_register(logic [CfgIdxW-1:0] index, logic [SideW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.note_register(index, value);
  endtask

  task automatic send_pixels();
    int unsigned gap;
    while (pixel_plan.size() != 0) begin
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      push    <= 1'b1;
      pixel_i <= pixel_plan[0];
      do @(posedge clk_i); while (full);
      board.add_pixel(pixel_plan.pop_front());
    end
    push <= 1'b0;
  endtask

  task automatic wait_idle();
    while (board.bytes_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Result side: pops with random pauses, or holds off for a long stretch
  // when asked, so that the block backs up into its input.
  initial begin
    int unsigned pause;
    int unsigned holds_taken;
    holds_taken = 0;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_asks != holds_taken) begin
        pause = HoldStretch;
        holds_taken++;
      end else begin
        pause = steady ? 0 : $urandom_range(0, 9);
      end
      if (pause != 0) begin
        pop <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      board.check_byte(result_o);
    end
  end

  initial begin
    int unsigned items;
    logic [31:0] r;
    board = new();
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_WIDTH;
    cfg_data_i  <= '0;
    push        <= 1'b0;
    pixel_i     <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // The reset geometry is 1x1, so each pixel is a complete file.
    plan_pixel(8'h00, 8'h00, 8'h00);
    plan_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixels();
    wait_idle();

    // Zero sides are taken as one; the spare index must be ignored.
    set_register(REG_WIDTH, '0);
    set_register(REG_HEIGHT, '0);
    set_register(RegSpare, '1);
    plan_pixel(8'hAA, 8'h55, 8'h0F);
    plan_pixel(8'hF0, 8'h0F, 8'h5A);
    send_pixels();
    wait_idle();

    // Oversized sides are capped, then shrunk while the frame is open.
    set_register(REG_WIDTH, '1);
    set_register(REG_HEIGHT, '1);
    plan_pixel(8'h01, 8'h80, 8'h7F);
    plan_pixel(8'hFE, 8'h02, 8'h40);
    plan_pixel(8'h10, 8'h20, 8'h30);
    send_pixels();
    wait_idle();
    set_register(REG_WIDTH, 13'd2);
    set_register(REG_HEIGHT, 13'd2);
    plan_pixel(8'h11, 8'h22, 8'h33);
    plan_pixel(8'h44, 8'h55, 8'h66);
    plan_pixel(8'h77, 8'h88, 8'h99);
    send_pixels();
    wait_idle();

    // Three pad bytes per row, then rows that need no padding at all.
    set_register(REG_WIDTH, 13'd3);
    set_register(REG_HEIGHT, 13'd1);
    for (int i = 0; i < 3; i++) plan_pixel(8'(i), 8'(i + 8), 8'(i + 16));
    send_pixels();
    wait_idle();
    set_register(REG_WIDTH, 13'd4);
    set_register(REG_HEIGHT, 13'd2);
    for (int i = 0; i < 8; i++) plan_pixel(8'(8'hC0 + i), 8'(8'h60 + i), 8'(8'h30 + i));
    send_pixels();

    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      if ($urandom_range(0, 3) != 0) set_register(REG_WIDTH, pick_side(5));
      if ($urandom_range(0, 3) != 0) set_register(REG_HEIGHT, pick_side(4));
      steady = (phase == 5);
      if (phase == 2) hold_asks++;
      items = $urandom_range(9, 13);
      repeat (items) begin
        r = $urandom;
        plan_pixel(r[7:0], r[15:8], r[23:16]);
      end
      send_pixels();
    end
    steady = 1'b0;

    wait_idle();
    repeat (24) @(posedge clk_i);
    board.close_out();
    if (board.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
src/bmpw_pkg.sv
src/bmpw_front.sv
src/bmpw_queue.sv
src/bmpw_back.sv
src/bmp_24bit_writer.sv
bench/bmp_24bit_writer_test.sv
